// ===== design/pdds_pkg.sv =====
// Shared types, constants and register codes for the distance-drive PID block.
package pdds_pkg;

  localparam int IntegralZone   = 150;
  localparam int SettleBand     = 20;
  localparam int GainFracBitsDf = 16;

  // Width of the exact PID sum before the fraction shift.
  localparam int RawW    = 56;
  localparam int CfgIdxW = 3;
  localparam int CfgDatW = 20;

  typedef enum logic [CfgIdxW-1:0] {
    CfgTarget    = 3'd0,
    CfgMaxPower  = 3'd1,
    CfgCallback  = 3'd2,
    CfgGainP     = 3'd3,
    CfgGainI     = 3'd4,
    CfgGainD     = 3'd5,
    CfgGainLine  = 3'd6,
    CfgExitDelay = 3'd7
  } cfg_idx_e;

  localparam logic signed [15:0] TargetRst    = 16'sd0;
  localparam logic [6:0]         MaxPowerRst  = 7'd127;
  localparam logic [14:0]        CallbackRst  = 15'd0;
  localparam logic [19:0]        GainPRst     = 20'd32768;
  localparam logic [19:0]        GainIRst     = 20'd328;
  localparam logic [19:0]        GainDRst     = 20'd6554;
  localparam logic [19:0]        GainLineRst  = 20'd0;
  localparam logic [15:0]        ExitDelayRst = 16'd350;

  typedef struct packed {
    logic signed [15:0] target_distance;
    logic [6:0]         max_power;
    logic [14:0]        callback_distance;
    logic [19:0]        gain_p;
    logic [19:0]        gain_i;
    logic [19:0]        gain_d;
    logic [19:0]        gain_line;
    logic [15:0]        exit_delay_ms;
  } cfg_t;

  typedef struct packed {
    logic               start_req;
    logic signed [15:0] left_travel;
    logic signed [15:0] right_travel;
    logic [31:0]        time_ms;
  } in_t;

  typedef struct packed {
    logic signed [7:0] left_power;
    logic signed [7:0] right_power;
    logic              callback_fire;
    logic              settled;
  } out_t;

  // Error terms after the state update.
  typedef struct packed {
    logic signed [16:0] err;
    logic signed [31:0] error_sum;
    logic signed [17:0] err_diff;
    logic signed [17:0] bal_diff;
    logic               callback_fire;
    logic               settled;
  } s1_t;

  // Registered gain products.
  typedef struct packed {
    logic signed [37:0] prod_p;
    logic signed [52:0] prod_i;
    logic signed [38:0] prod_d;
    logic signed [38:0] prod_line;
    logic               callback_fire;
    logic               settled;
  } s2_t;

endpackage

// ===== design/pdds_stream_if.sv =====
// Valid/ready stream interface carrying one payload word.
interface pdds_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== design/pdds_cfg_regs.sv =====
// Configuration register file for the distance-drive PID block.
module pdds_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [pdds_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [pdds_pkg::CfgDatW-1:0]   cfg_wdata_i,
  output pdds_pkg::cfg_t                 cfg_o
);
  import pdds_pkg::*;

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.target_distance   <= TargetRst;
      cfg_q.max_power         <= MaxPowerRst;
      cfg_q.callback_distance <= CallbackRst;
      cfg_q.gain_p            <= GainPRst;
      cfg_q.gain_i            <= GainIRst;
      cfg_q.gain_d            <= GainDRst;
      cfg_q.gain_line         <= GainLineRst;
      cfg_q.exit_delay_ms     <= ExitDelayRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CfgTarget:    cfg_q.target_distance   <= $signed(cfg_wdata_i[15:0]);
        CfgMaxPower:  cfg_q.max_power         <= cfg_wdata_i[6:0];
        CfgCallback:  cfg_q.callback_distance <= cfg_wdata_i[14:0];
        CfgGainP:     cfg_q.gain_p            <= cfg_wdata_i;
        CfgGainI:     cfg_q.gain_i            <= cfg_wdata_i;
        CfgGainD:     cfg_q.gain_d            <= cfg_wdata_i;
        CfgGainLine:  cfg_q.gain_line         <= cfg_wdata_i;
        CfgExitDelay: cfg_q.exit_delay_ms     <= cfg_wdata_i[15:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== design/pdds_power.sv =====
// Sums gain products, scales, clamps and saturates the drive powers.
module pdds_power #(
  parameter int GainFracBits = pdds_pkg::GainFracBitsDf
) (
  input  pdds_pkg::s2_t  s2_i,
  input  pdds_pkg::cfg_t cfg_i,
  output pdds_pkg::out_t res_o
);
  import pdds_pkg::*;

  localparam int LineW = 40;
  localparam int PowW  = RawW - GainFracBits;
  localparam int BalW  = LineW - GainFracBits;
  localparam logic signed [RawW-1:0]  RawMask  = RawW'((1 << GainFracBits) - 1);
  localparam logic signed [LineW-1:0] LineMask = LineW'((1 << GainFracBits) - 1);
  localparam logic signed [PowW:0]    Pos127   = (PowW+1)'(127);
  localparam logic signed [PowW:0]    Neg127   = (PowW+1)'(-127);

  logic                    neg;
  logic signed [RawW-1:0]  raw, raw_dir, pow_full;
  logic signed [LineW-1:0] line_dir, bal_full;
  logic signed [PowW-1:0]  pow_sh, pow_max, pow_cl;
  logic signed [PowW:0]    pow_ext, pow_bal;
  logic signed [7:0]       lp, rp;

  always_comb begin
    neg     = cfg_i.target_distance[15];
    raw     = RawW'(s2_i.prod_p) + RawW'(s2_i.prod_i) + RawW'(s2_i.prod_d);
    raw_dir = neg ? -raw : raw;
    // truncate toward zero: bias negatives before the arithmetic shift
    pow_full = raw_dir[RawW-1] ? ((raw_dir + RawMask) >>> GainFracBits)
                               : (raw_dir >>> GainFracBits);
    pow_sh   = pow_full[PowW-1:0];

    line_dir = neg ? -LineW'(s2_i.prod_line) : LineW'(s2_i.prod_line);
    bal_full = line_dir[LineW-1] ? ((line_dir + LineMask) >>> GainFracBits)
                                 : (line_dir >>> GainFracBits);

    // clamp only on the drive-direction side
    pow_max = PowW'($signed({1'b0, cfg_i.max_power}));
    pow_cl  = pow_sh;
    if (!neg && (pow_sh > pow_max)) begin
      pow_cl = pow_max;
    end
    if (neg && (pow_sh < -pow_max)) begin
      pow_cl = -pow_max;
    end

    pow_ext = (PowW+1)'(pow_cl);
    pow_bal = pow_ext + (PowW+1)'($signed(bal_full[BalW-1:0]));

    if (pow_ext > Pos127) begin
      lp = 8'sd127;
    end else if (pow_ext < Neg127) begin
      lp = -8'sd127;
    end else begin
      lp = pow_ext[7:0];
    end

    if (pow_bal > Pos127) begin
      rp = 8'sd127;
    end else if (pow_bal < Neg127) begin
      rp = -8'sd127;
    end else begin
      rp = pow_bal[7:0];
    end

    res_o.left_power    = s2_i.settled ? 8'sd0 : lp;
    res_o.right_power   = s2_i.settled ? 8'sd0 : rp;
    res_o.callback_fire = s2_i.callback_fire;
    res_o.settled       = s2_i.settled;
  end

endmodule

// ===== design/pid_drive_distance_settle_top.sv =====
// Distance-drive PID with integral zone and settle detection: top level.
// Pipeline: input, error state, gain product and result registers (4 register stages).
// Throughput: one word per cycle while the output is not stalled; the error/integral/settle
// state closes at the input register stage, gain products take a stage of their own.
// Reset: asynchronous, active low; empties the pipeline, restores register
// defaults and the controller state (integral zero, waiting for band entry).
module pid_drive_distance_settle_top #(
  parameter int GainFracBits = pdds_pkg::GainFracBitsDf
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pdds_stream_if.sink                  in_i,
  pdds_stream_if.source                out_o,
  input  logic                         cfg_we_i,
  input  logic [pdds_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pdds_pkg::CfgDatW-1:0] cfg_wdata_i
);
  import pdds_pkg::*;

  localparam logic signed [17:0] ZoneS = 18'(IntegralZone);
  localparam logic signed [17:0] BandS = 18'(SettleBand);

  cfg_t cfg;

  pdds_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  // pipeline valids and per-stage ready
  logic v0_q, v1_q, v2_q, vo_q;
  logic rdy0, rdy1, rdy2, rdy3;
  in_t  in0_q;
  s1_t  s1_d, s1_q;
  s2_t  s2_d, s2_q;
  out_t res_d, res_q;

  assign rdy3 = !vo_q || out_o.ready;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;
  assign rdy0 = !v0_q || rdy1;

  assign in_i.ready  = rdy0;
  assign out_o.valid = vo_q;
  assign out_o.data  = res_q;

  // controller state
  logic signed [31:0] error_sum_q, error_sum_d;
  logic signed [16:0] last_error_q, last_error_d;
  logic               wait_first_q, wait_first_d;
  logic               entered_q, entered_d;
  logic [31:0]        pause_time_q, pause_time_d;
  logic               done_q, done_d;

  logic signed [16:0] sum_lr, sum_adj, avg;
  logic signed [17:0] aavg, tgt, err, err_diff, bal_diff;
  logic [16:0]        abs_l, abs_r;
  logic signed [31:0] es_cur;
  logic signed [16:0] le_cur;
  logic               wf_cur, eb_cur, done_cur;
  logic [31:0]        pt_cur, pt1;
  logic signed [32:0] es_sum;
  logic signed [31:0] es_sat;
  logic               band_lo, band_hi, first, eb1, chk, done1;

  always_comb begin
    sum_lr  = 17'(in0_q.left_travel) + 17'(in0_q.right_travel);
    // halve toward zero
    sum_adj = sum_lr + $signed({16'd0, sum_lr[16]});
    avg     = sum_adj >>> 1;
    aavg    = avg[16] ? -18'(avg) : 18'(avg);
    tgt     = cfg.target_distance[15] ? -18'(cfg.target_distance)
                                      : 18'(cfg.target_distance);
    err     = tgt - aavg;

    abs_l    = in0_q.left_travel[15] ? 17'(-18'(in0_q.left_travel))
                                     : 17'(in0_q.left_travel);
    abs_r    = in0_q.right_travel[15] ? 17'(-18'(in0_q.right_travel))
                                      : 17'(in0_q.right_travel);
    bal_diff = $signed({1'b0, abs_l}) - $signed({1'b0, abs_r});

    // start clears the state before this word is applied
    es_cur   = in0_q.start_req ? 32'sd0 : error_sum_q;
    le_cur   = in0_q.start_req ? 17'sd0 : last_error_q;
    wf_cur   = in0_q.start_req ? 1'b1 : wait_first_q;
    eb_cur   = in0_q.start_req ? 1'b0 : entered_q;
    pt_cur   = in0_q.start_req ? 32'd0 : pause_time_q;
    done_cur = in0_q.start_req ? 1'b0 : done_q;

    es_sum = 33'(es_cur) + 33'(err);
    if (es_sum[32] != es_sum[31]) begin
      es_sat = es_sum[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end else begin
      es_sat = es_sum[31:0];
    end

    err_diff = err - 18'(le_cur);

    band_lo = aavg > (tgt - BandS);
    band_hi = aavg < (tgt + BandS);
    first   = band_lo && wf_cur;
    pt1     = first ? in0_q.time_ms : pt_cur;
    eb1     = eb_cur || first;
    chk     = eb1 && ({1'b0, in0_q.time_ms} > ({1'b0, pt1} + 33'(cfg.exit_delay_ms)));
    done1   = chk && band_lo && band_hi;

    // frozen once done
    error_sum_d  = done_cur ? es_cur : ((err < ZoneS) ? es_sat : 32'sd0);
    last_error_d = done_cur ? le_cur : err[16:0];
    wait_first_d = done_cur ? wf_cur : (wf_cur && !first);
    entered_d    = done_cur ? eb_cur : eb1;
    pause_time_d = done_cur ? pt_cur : ((chk && !done1) ? in0_q.time_ms : pt1);
    done_d       = done_cur || done1;

    s1_d.err           = err[16:0];
    s1_d.error_sum     = error_sum_d;
    s1_d.err_diff      = err_diff;
    s1_d.bal_diff      = bal_diff;
    s1_d.callback_fire = 18'(avg) > $signed({3'b000, cfg.callback_distance});
    s1_d.settled       = done_d;
  end

  always_comb begin
    s2_d.prod_p        = $signed({1'b0, cfg.gain_p}) * s1_q.err;
    s2_d.prod_i        = $signed({1'b0, cfg.gain_i}) * s1_q.error_sum;
    s2_d.prod_d        = $signed({1'b0, cfg.gain_d}) * s1_q.err_diff;
    s2_d.prod_line     = $signed({1'b0, cfg.gain_line}) * s1_q.bal_diff;
    s2_d.callback_fire = s1_q.callback_fire;
    s2_d.settled       = s1_q.settled;
  end

  pdds_power #(
    .GainFracBits(GainFracBits)
  ) u_power (
    .s2_i (s2_q),
    .cfg_i(cfg),
    .res_o(res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy0) v0_q <= in_i.valid;
      if (rdy1) v1_q <= v0_q;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) vo_q <= v2_q;
    end
  end

  // advance the controller state as a word leaves the input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      error_sum_q  <= 32'sd0;
      last_error_q <= 17'sd0;
      wait_first_q <= 1'b1;
      entered_q    <= 1'b0;
      pause_time_q <= 32'd0;
      done_q       <= 1'b0;
    end else if (v0_q && rdy1) begin
      error_sum_q  <= error_sum_d;
      last_error_q <= last_error_d;
      wait_first_q <= wait_first_d;
      entered_q    <= entered_d;
      pause_time_q <= pause_time_d;
      done_q       <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && in_i.valid) in0_q <= in_i.data;
    if (rdy1 && v0_q)       s1_q  <= s1_d;
    if (rdy2 && v1_q)       s2_q  <= s2_d;
    if (rdy3 && v2_q)       res_q <= res_d;
  end

endmodule

// ===== design/pdds_checker.sv =====
// Port-level checks for the distance-drive PID block, bound to the top level.
module pdds_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_i,
  input logic           out_ready_i,
  input pdds_pkg::out_t out_data_i
);
  import pdds_pkg::*;

  // hold a stalled result word
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result word changed while stalled");

  a_settled_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.settled |->
      out_data_i.left_power == 8'sd0 && out_data_i.right_power == 8'sd0)
    else $error("nonzero power after settling");

  a_power_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |->
      out_data_i.left_power != -8'sd128 && out_data_i.right_power != -8'sd128)
    else $error("power outside saturation range");

endmodule

bind pid_drive_distance_settle_top pdds_checker u_pdds_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_data_i (out_o.data)
);
